### sv/touch_sample_qualify_calibrate_assert.svh
// Assertion macros for the touch sample qualifier RTL.
`ifndef TOUCH_SAMPLE_QUALIFY_CALIBRATE_ASSERT_SVH
`define TOUCH_SAMPLE_QUALIFY_CALIBRATE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSQC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TSQC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/tsqc_pkg.sv
// Shared types, codes and constants of the touch sample qualifier.
`default_nettype none

package tsqc_pkg;

    localparam int DATA_W    = 12;
    localparam int AXIS_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int DIV_W     = 24;   // |raw - offset| * size fits 24 bits
    localparam int POS_W     = 26;   // signed scaled value after mirroring

    // axis codes
    localparam logic [AXIS_W-1:0] AXIS_P = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_X = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Y = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPAN_X    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPAN_Y    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ORIENT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_W  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_H  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd7;

    // orientation flag bit positions
    localparam int FLAG_SWAP_BIT     = 0;
    localparam int FLAG_MIRROR_X_BIT = 1;
    localparam int FLAG_MIRROR_Y_BIT = 2;

    localparam logic [DATA_W-1:0] SPREAD_LIMIT = 12'd30;

    // register reset values
    localparam logic [DATA_W-1:0] RST_OFFSET    = 12'd1;
    localparam logic [DATA_W-1:0] RST_SPAN      = 12'd1;
    localparam logic [DATA_W-1:0] RST_SCREEN_W  = 12'd320;
    localparam logic [DATA_W-1:0] RST_SCREEN_H  = 12'd240;
    localparam logic [DATA_W-1:0] RST_THRESHOLD = 12'd40;
    localparam logic [DATA_W-1:0] SAMPLE_MAX    = 12'hFFF;

    // result kinds
    localparam logic [1:0] RES_PARTIAL = 2'd0;
    localparam logic [1:0] RES_NOTOUCH = 2'd1;
    localparam logic [1:0] RES_POINT   = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic       acc;        // fold accepted sample into the group
        logic       clr;        // restart the group
        logic       avg_take;   // latch group average
        logic       hold_p;     // keep pressure, move to X
        logic       hold_x;     // keep raw X, move to Y
        logic       mul_go;     // register |raw - offset| * size
        logic       cal_start;  // divider: product / span
        logic       take_q;     // latch signed scaled coordinate
        logic       sel_y;      // calibration step works on Y
        logic       phase_home; // back to pressure axis
        logic       out_load;   // load the result register
        logic [1:0] out_kind;
    } tsqc_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic              full;
        logic              spread_bad;
        logic              div_done;
        logic [AXIS_W-1:0] phase;
        logic              below_thr;
        logic              out_free;
    } tsqc_status_t;

    // zero written to an offset or span becomes one
    function automatic logic [DATA_W-1:0] nz(input logic [DATA_W-1:0] v);
        return (v == '0) ? 12'd1 : v;
    endfunction

endpackage

`default_nettype wire

### sv/tsqc_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module tsqc_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [tsqc_pkg::DIV_W-1:0]  dividend,
    input  wire logic [tsqc_pkg::DATA_W-1:0] divisor,
    output logic                            busy,
    output logic                            done,
    output logic [tsqc_pkg::DIV_W-1:0]       quotient
);
    import tsqc_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_W - 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [DATA_W-1:0]   rem_reg, rem_next;
    logic [DIV_W-1:0]    q_reg, q_next;
    logic [DATA_W-1:0]   dvs_reg, dvs_next;
    logic [DATA_W:0]     shifted;
    logic [DATA_W:0]     trial;

    // one shift-subtract step
    always_comb
    begin
        shifted   = {rem_reg, q_reg[DIV_W-1]};
        trial     = shifted - {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            q_next    = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[DATA_W])
            begin
                rem_next = trial[DATA_W-1:0];
                q_next   = {q_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DATA_W-1:0];
                q_next   = {q_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

### sv/tsqc_dp.sv
// Datapath: registers, group statistics, calibration arithmetic, result register.
`default_nettype none
`include "touch_sample_qualify_calibrate_assert.svh"

module tsqc_dp #(
    parameter int SAMPLES_PER_AXIS = 4
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [tsqc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tsqc_pkg::DATA_W-1:0]    cfg_data,
    input  wire logic [tsqc_pkg::DATA_W-1:0]    sample,
    input  wire tsqc_pkg::tsqc_cmd_t            cmd,
    output tsqc_pkg::tsqc_status_t              status,
    output logic                               result_valid,
    input  wire logic                          result_stall,
    output logic [tsqc_pkg::AXIS_W-1:0]         next_axis,
    output logic                               frame_done,
    output logic                               touched,
    output logic                               on_screen,
    output logic [tsqc_pkg::DATA_W-1:0]         pos_x,
    output logic [tsqc_pkg::DATA_W-1:0]         pos_y,
    output logic [tsqc_pkg::DATA_W-1:0]         pressure
);
    import tsqc_pkg::*;

    localparam int CNT_W = $clog2(SAMPLES_PER_AXIS + 1);
    localparam int SUM_W = DATA_W + $clog2(SAMPLES_PER_AXIS);
    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(SAMPLES_PER_AXIS);

    // group average as sum * ceil(2^SH / N) >> SH, exact for any sum below 2^SUM_W
    localparam int RECIP_SH = SUM_W + $clog2(SAMPLES_PER_AXIS);
    localparam int RECIP_W  = SUM_W + 1;
    localparam int APROD_W  = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_M =
        RECIP_W'(((64'd1 << RECIP_SH) + 64'(SAMPLES_PER_AXIS) - 64'd1) /
                 64'(SAMPLES_PER_AXIS));

    // configuration registers
    logic [DATA_W-1:0] offset_x_reg, span_x_reg, offset_y_reg, span_y_reg;
    logic [2:0]        orient_reg;
    logic [DATA_W-1:0] screen_w_reg, screen_h_reg, thr_reg;

    // group and frame state
    logic [CNT_W-1:0]  cnt_reg;
    logic [DATA_W-1:0] min_reg, max_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [AXIS_W-1:0] phase_reg;
    logic [DATA_W-1:0] avg_reg, held_p_reg, held_x_reg;

    // calibration state
    logic [DIV_W-1:0]       prod_reg;
    logic                   prod_neg_reg;
    logic signed [POS_W-1:0] xx_reg, yy_reg;

    // result register
    logic              result_valid_reg, result_valid_next;
    logic [AXIS_W-1:0] next_axis_reg;
    logic              frame_done_reg, touched_reg, on_screen_reg;
    logic [DATA_W-1:0] pos_x_reg, pos_y_reg, pressure_reg;

    // divider
    logic              div_start, div_busy, div_done;
    logic [DIV_W-1:0]  div_dividend, div_q;
    logic [DATA_W-1:0] div_divisor;

    // combinational helpers
    logic [APROD_W-1:0]      avg_prod;
    logic [DATA_W-1:0]       avg_calc;
    logic                    swap;
    logic [DATA_W-1:0]       raw_sel, off_sel, size_sel;
    logic [DATA_W:0]         diff;
    logic [DATA_W-1:0]       diff_mag;
    logic [POS_W-1:0]        q_ext, q_signed;
    logic signed [POS_W-1:0] size_w_s, size_h_s, xm, ym;
    logic                    on_next;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_x_reg <= RST_OFFSET;
            span_x_reg   <= RST_SPAN;
            offset_y_reg <= RST_OFFSET;
            span_y_reg   <= RST_SPAN;
            orient_reg   <= '0;
            screen_w_reg <= RST_SCREEN_W;
            screen_h_reg <= RST_SCREEN_H;
            thr_reg      <= RST_THRESHOLD;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_OFFSET_X:  offset_x_reg <= nz(cfg_data);
                REG_SPAN_X:    span_x_reg   <= nz(cfg_data);
                REG_OFFSET_Y:  offset_y_reg <= nz(cfg_data);
                REG_SPAN_Y:    span_y_reg   <= nz(cfg_data);
                REG_ORIENT:    orient_reg   <= cfg_data[2:0];
                REG_SCREEN_W:  screen_w_reg <= cfg_data;
                REG_SCREEN_H:  screen_h_reg <= cfg_data;
                REG_THRESHOLD: thr_reg      <= cfg_data;
                default:       ;
            endcase
        end
    end

    // group statistics and frame phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            min_reg    <= SAMPLE_MAX;
            max_reg    <= '0;
            sum_reg    <= '0;
            phase_reg  <= AXIS_P;
            held_p_reg <= '0;
            held_x_reg <= '0;
        end
        else
        begin
            if (cmd.clr)
            begin
                cnt_reg <= '0;
                min_reg <= SAMPLE_MAX;
                max_reg <= '0;
                sum_reg <= '0;
            end
            else if (cmd.acc)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (sample < min_reg)
                    min_reg <= sample;
                if (sample > max_reg)
                    max_reg <= sample;
                sum_reg <= sum_reg + SUM_W'(sample);
            end
            if (cmd.hold_p)
            begin
                held_p_reg <= avg_reg;
                phase_reg  <= AXIS_X;
            end
            else if (cmd.hold_x)
            begin
                held_x_reg <= avg_reg;
                phase_reg  <= AXIS_Y;
            end
            else if (cmd.phase_home)
            begin
                phase_reg <= AXIS_P;
            end
        end
    end

    // group average by reciprocal multiply
    always_comb
    begin
        avg_prod = APROD_W'(sum_reg) * APROD_W'(RECIP_M);
        avg_calc = avg_prod[RECIP_SH +: DATA_W];
    end

    // divider operands: calibration product over span
    assign div_start    = cmd.cal_start;
    assign div_dividend = prod_reg;
    assign div_divisor  = cmd.sel_y ? span_y_reg : span_x_reg;

    tsqc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    // operand select and magnitude of raw - offset
    always_comb
    begin
        swap     = orient_reg[FLAG_SWAP_BIT];
        raw_sel  = (cmd.sel_y ^ swap) ? avg_reg : held_x_reg;
        off_sel  = cmd.sel_y ? offset_y_reg : offset_x_reg;
        size_sel = cmd.sel_y ? screen_h_reg : screen_w_reg;
        diff     = {1'b0, raw_sel} - {1'b0, off_sel};
        diff_mag = diff[DATA_W] ? DATA_W'((DATA_W+1)'(0) - diff) : diff[DATA_W-1:0];
        q_ext    = POS_W'(div_q);
        q_signed = prod_neg_reg ? (POS_W'(0) - q_ext) : q_ext;
    end

    // calibration registers
    always_ff @(posedge clk)
    begin
        if (cmd.avg_take)
            avg_reg <= avg_calc;
        if (cmd.mul_go)
        begin
            prod_reg     <= DIV_W'(diff_mag) * DIV_W'(size_sel);
            prod_neg_reg <= diff[DATA_W];
        end
        if (cmd.take_q)
        begin
            if (cmd.sel_y)
                yy_reg <= $signed(q_signed);
            else
                xx_reg <= $signed(q_signed);
        end
    end

    // mirroring and screen bounds test
    always_comb
    begin
        size_w_s = $signed(POS_W'(screen_w_reg));
        size_h_s = $signed(POS_W'(screen_h_reg));
        xm = orient_reg[FLAG_MIRROR_X_BIT] ? (size_w_s - xx_reg) : xx_reg;
        ym = orient_reg[FLAG_MIRROR_Y_BIT] ? (size_h_s - yy_reg) : yy_reg;
        on_next = !xm[POS_W-1] && !ym[POS_W-1] && (xm < size_w_s) && (ym < size_h_s);
    end

    // result handshake
    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (cmd.out_load)
            result_valid_next = 1'b1;
        else if (!result_stall)
            result_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= result_valid_next;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            next_axis_reg  <= phase_reg;
            frame_done_reg <= 1'b0;
            touched_reg    <= 1'b0;
            on_screen_reg  <= 1'b0;
            pos_x_reg      <= '0;
            pos_y_reg      <= '0;
            pressure_reg   <= '0;
            case (cmd.out_kind)
                RES_NOTOUCH:
                begin
                    frame_done_reg <= 1'b1;
                    pressure_reg   <= avg_reg;
                end
                RES_POINT:
                begin
                    frame_done_reg <= 1'b1;
                    touched_reg    <= 1'b1;
                    on_screen_reg  <= on_next;
                    pressure_reg   <= held_p_reg;
                    if (on_next)
                    begin
                        pos_x_reg <= xm[DATA_W-1:0];
                        pos_y_reg <= ym[DATA_W-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    // status to controller
    always_comb
    begin
        status.full       = (cnt_reg == CNT_FULL);
        status.spread_bad = (max_reg - min_reg) > SPREAD_LIMIT;
        status.div_done   = div_done;
        status.phase      = phase_reg;
        status.below_thr  = (avg_reg <= thr_reg);
        status.out_free   = !result_valid_reg || !result_stall;
    end

    assign result_valid = result_valid_reg;
    assign next_axis    = next_axis_reg;
    assign frame_done   = frame_done_reg;
    assign touched      = touched_reg;
    assign on_screen    = on_screen_reg;
    assign pos_x        = pos_x_reg;
    assign pos_y        = pos_y_reg;
    assign pressure     = pressure_reg;

    `TSQC_ASSERT_NOW(a_load_free, cmd.out_load, !result_valid_reg || !result_stall,
        "result register overwritten while a transfer is pending")
    `TSQC_ASSERT_NOW(a_acc_not_full, cmd.acc, cnt_reg != CNT_FULL,
        "sample folded into a full group")
    `TSQC_ASSERT_NEXT(a_acc_count, cmd.acc && !cmd.clr,
        cnt_reg == CNT_W'($past(cnt_reg) + 1'b1), "group count did not advance")
    `TSQC_ASSERT_NOW(a_div_idle, div_start, !div_busy,
        "divider started while busy")

endmodule

`default_nettype wire

### sv/tsqc_ctrl.sv
// Controller: sequences sampling, averaging, calibration and result loading.
`default_nettype none

module tsqc_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   sample_valid,
    output logic                        sample_stall,
    input  wire tsqc_pkg::tsqc_status_t status,
    output tsqc_pkg::tsqc_cmd_t         cmd
);
    import tsqc_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_EVAL   = 4'd1;
    localparam logic [3:0] S_DECIDE = 4'd3;
    localparam logic [3:0] S_STX    = 4'd4;
    localparam logic [3:0] S_WX     = 4'd5;
    localparam logic [3:0] S_MY     = 4'd6;
    localparam logic [3:0] S_STY    = 4'd7;
    localparam logic [3:0] S_WY     = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;

    logic [3:0] state_reg, state_next;
    logic [1:0] kind_reg, kind_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        cmd.out_kind = kind_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd.acc    = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (!status.full)
                begin
                    kind_next  = RES_PARTIAL;
                    state_next = S_OUT;
                end
                else if (status.spread_bad)
                begin
                    cmd.clr    = 1'b1;
                    kind_next  = RES_PARTIAL;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.avg_take = 1'b1;
                    cmd.clr      = 1'b1;
                    state_next   = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                case (status.phase)
                    AXIS_P:
                    begin
                        if (status.below_thr)
                            kind_next = RES_NOTOUCH;
                        else
                        begin
                            cmd.hold_p = 1'b1;
                            kind_next  = RES_PARTIAL;
                        end
                        state_next = S_OUT;
                    end
                    AXIS_X:
                    begin
                        cmd.hold_x = 1'b1;
                        kind_next  = RES_PARTIAL;
                        state_next = S_OUT;
                    end
                    AXIS_Y:
                    begin
                        cmd.mul_go = 1'b1;
                        state_next = S_STX;
                    end
                    default:
                    begin
                        cmd.phase_home = 1'b1;
                        kind_next      = RES_PARTIAL;
                        state_next     = S_OUT;
                    end
                endcase
            end
            S_STX:
            begin
                cmd.cal_start = 1'b1;
                state_next    = S_WX;
            end
            S_WX:
            begin
                if (status.div_done)
                begin
                    cmd.take_q = 1'b1;
                    state_next = S_MY;
                end
            end
            S_MY:
            begin
                cmd.sel_y  = 1'b1;
                cmd.mul_go = 1'b1;
                state_next = S_STY;
            end
            S_STY:
            begin
                cmd.sel_y     = 1'b1;
                cmd.cal_start = 1'b1;
                state_next    = S_WY;
            end
            S_WY:
            begin
                cmd.sel_y = 1'b1;
                if (status.div_done)
                begin
                    cmd.take_q     = 1'b1;
                    cmd.phase_home = 1'b1;
                    kind_next      = RES_POINT;
                    state_next     = S_OUT;
                end
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg  <= RES_PARTIAL;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    assign sample_stall = (state_reg != S_IDLE);

endmodule

`default_nettype wire

### sv/touch_sample_qualify_calibrate.sv
// Top level of the touch sample qualifier and calibrator.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+---------------------------------
//  config   | in        | cfg_we                    | cfg_index, cfg_data
//  sample   | in        | sample_valid/sample_stall | sample
//  result   | out       | result_valid/result_stall | next_axis .. pressure
//
// A sample that closes no group, or a rejected group, passes states EVAL and OUT before
// its result is loaded; a kept pressure or X group also passes DECIDE (reciprocal average).
// A kept Y group runs two restoring divisions by span before its result is loaded.
// The next sample is taken in the cycle after the result is loaded; none is taken earlier.
// Reset clears control state and loads register defaults; there is no clearing pass.
// While a result waits under result_stall the next sample is still taken.
`default_nettype none

module touch_sample_qualify_calibrate #(
    parameter int SAMPLES_PER_AXIS = 4
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [tsqc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tsqc_pkg::DATA_W-1:0]    cfg_data,
    input  wire logic                          sample_valid,
    output logic                               sample_stall,
    input  wire logic [tsqc_pkg::DATA_W-1:0]    sample,
    output logic                               result_valid,
    input  wire logic                          result_stall,
    output logic [tsqc_pkg::AXIS_W-1:0]         next_axis,
    output logic                               frame_done,
    output logic                               touched,
    output logic                               on_screen,
    output logic [tsqc_pkg::DATA_W-1:0]         pos_x,
    output logic [tsqc_pkg::DATA_W-1:0]         pos_y,
    output logic [tsqc_pkg::DATA_W-1:0]         pressure
);
    import tsqc_pkg::*;

    tsqc_cmd_t    cmd;
    tsqc_status_t status;

    tsqc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .status       (status),
        .cmd          (cmd)
    );

    tsqc_dp #(
        .SAMPLES_PER_AXIS (SAMPLES_PER_AXIS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample       (sample),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .next_axis    (next_axis),
        .frame_done   (frame_done),
        .touched      (touched),
        .on_screen    (on_screen),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pressure     (pressure)
    );

endmodule

`default_nettype wire

### test/touch_sample_qualify_calibrate_tb.sv
// Self-checking testbench for the touch sample qualifier and calibrator.
module touch_sample_qualify_calibrate_tb;
    import tsqc_pkg::*;

    localparam int GROUP_LEN      = 4;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int QUIET_LIMIT    = 5000;
    localparam int DRAIN_CYCLES   = 120;
    localparam int MAX_REPORTS    = 10;
    localparam int BASE_MAX       = 4095 - 30;   // steady group stays in 12 bits

    typedef logic [DATA_W-1:0] sample_q_t[$];

    typedef enum int {GRP_STEADY, GRP_BROKEN, GRP_NOISE} group_kind_t;

    typedef struct packed {
        logic [AXIS_W-1:0] next_axis;
        logic              frame_done;
        logic              touched;
        logic              on_screen;
        logic [DATA_W-1:0] pos_x;
        logic [DATA_W-1:0] pos_y;
        logic [DATA_W-1:0] pressure;
    } touch_result_t;

    typedef struct {
        logic [DATA_W-1:0] off_x;
        logic [DATA_W-1:0] span_x;
        logic [DATA_W-1:0] off_y;
        logic [DATA_W-1:0] span_y;
        logic [DATA_W-1:0] orient;
        logic [DATA_W-1:0] width;
        logic [DATA_W-1:0] height;
        logic [DATA_W-1:0] thr;
    } touch_cfg_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0]    cfg_data;
    logic                 sample_valid;
    logic                 sample_stall;
    logic [DATA_W-1:0]    sample;
    logic                 result_valid;
    logic                 result_stall;
    logic [AXIS_W-1:0]    next_axis;
    logic                 frame_done;
    logic                 touched;
    logic                 on_screen;
    logic [DATA_W-1:0]    pos_x;
    logic [DATA_W-1:0]    pos_y;
    logic [DATA_W-1:0]    pressure;

    // predictor copy of registers
    logic [DATA_W-1:0] cal_off_x;
    logic [DATA_W-1:0] cal_span_x;
    logic [DATA_W-1:0] cal_off_y;
    logic [DATA_W-1:0] cal_span_y;
    logic [2:0]        cal_orient;
    logic [DATA_W-1:0] cal_width;
    logic [DATA_W-1:0] cal_height;
    logic [DATA_W-1:0] cal_thr;

    // predictor copy of qualifier state
    logic [AXIS_W-1:0] cur_axis;
    int                grp_count;
    logic [DATA_W-1:0] grp_min;
    logic [DATA_W-1:0] grp_max;
    int                grp_sum;
    logic [DATA_W-1:0] kept_pressure;
    logic [DATA_W-1:0] kept_raw_x;

    touch_result_t pending_results[$];
    int            mismatch_count;
    bit            holdoff_request;

    touch_sample_qualify_calibrate #(
        .SAMPLES_PER_AXIS(GROUP_LEN)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .next_axis    (next_axis),
        .frame_done   (frame_done),
        .touched      (touched),
        .on_screen    (on_screen),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pressure     (pressure)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic void clear_group();
        grp_count = 0;
        grp_min   = SAMPLE_MAX;
        grp_max   = '0;
        grp_sum   = 0;
    endfunction

    function automatic void reset_touch_model();
        cal_off_x     = RST_OFFSET;
        cal_span_x    = RST_SPAN;
        cal_off_y     = RST_OFFSET;
        cal_span_y    = RST_SPAN;
        cal_orient    = '0;
        cal_width     = RST_SCREEN_W;
        cal_height    = RST_SCREEN_H;
        cal_thr       = RST_THRESHOLD;
        cur_axis      = AXIS_P;
        kept_pressure = '0;
        kept_raw_x    = '0;
        clear_group();
    endfunction

    function automatic void model_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [DATA_W-1:0] value);
        case (idx)
            REG_OFFSET_X:  cal_off_x  = (value == '0) ? 12'd1 : value;
            REG_SPAN_X:    cal_span_x = (value == '0) ? 12'd1 : value;
            REG_OFFSET_Y:  cal_off_y  = (value == '0) ? 12'd1 : value;
            REG_SPAN_Y:    cal_span_y = (value == '0) ? 12'd1 : value;
            REG_ORIENT:    cal_orient = value[2:0];
            REG_SCREEN_W:  cal_width  = value;
            REG_SCREEN_H:  cal_height = value;
            REG_THRESHOLD: cal_thr    = value;
            default: ;
        endcase
    endfunction

    // signed (raw - offset) * size / span, truncating toward zero
    function automatic int scale_coord(input logic [DATA_W-1:0] raw, input logic [DATA_W-1:0] off,
                                       input logic [DATA_W-1:0] size,
                                       input logic [DATA_W-1:0] span);
        int d;
        d = int'(raw) - int'(off);
        return (d * int'(size)) / int'(span);
    endfunction

    function automatic touch_result_t predict_touch_result(input logic [DATA_W-1:0] s);
        touch_result_t     r;
        logic [DATA_W-1:0] avg;
        logic [DATA_W-1:0] ra;
        logic [DATA_W-1:0] rb;
        int                xx;
        int                yy;
        r = '0;
        if (s < grp_min)
            grp_min = s;
        if (s > grp_max)
            grp_max = s;
        grp_sum   = grp_sum + int'(s);
        grp_count = grp_count + 1;

        // group still filling
        if (grp_count < GROUP_LEN)
        begin
            r.next_axis = cur_axis;
            return r;
        end

        // too much spread: same axis again
        if (grp_max - grp_min > SPREAD_LIMIT)
        begin
            clear_group();
            r.next_axis = cur_axis;
            return r;
        end

        avg = DATA_W'(grp_sum / GROUP_LEN);
        clear_group();

        if (cur_axis == AXIS_P)
        begin
            if (avg <= cal_thr)
            begin
                r.next_axis  = AXIS_P;
                r.frame_done = 1'b1;
                r.pressure   = avg;
                return r;
            end
            kept_pressure = avg;
            cur_axis      = AXIS_X;
            r.next_axis   = cur_axis;
            return r;
        end

        if (cur_axis == AXIS_X)
        begin
            kept_raw_x  = avg;
            cur_axis    = AXIS_Y;
            r.next_axis = cur_axis;
            return r;
        end

        // Y group closed: calibrate
        ra = kept_raw_x;
        rb = avg;
        if (cal_orient[FLAG_SWAP_BIT])
        begin
            ra = avg;
            rb = kept_raw_x;
        end
        xx = scale_coord(ra, cal_off_x, cal_width, cal_span_x);
        yy = scale_coord(rb, cal_off_y, cal_height, cal_span_y);
        if (cal_orient[FLAG_MIRROR_X_BIT])
            xx = int'(cal_width) - xx;
        if (cal_orient[FLAG_MIRROR_Y_BIT])
            yy = int'(cal_height) - yy;
        cur_axis     = AXIS_P;
        r.next_axis  = AXIS_P;
        r.frame_done = 1'b1;
        r.touched    = 1'b1;
        r.pressure   = kept_pressure;
        if (xx >= 0 && yy >= 0 && xx < int'(cal_width) && yy < int'(cal_height))
        begin
            r.on_screen = 1'b1;
            r.pos_x     = xx[DATA_W-1:0];
            r.pos_y     = yy[DATA_W-1:0];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus generation
    // ------------------------------------------------------------------
    function automatic sample_q_t make_group(input group_kind_t kind, input int base);
        sample_q_t g;
        int        lo;
        int        d;
        int        a;
        case (kind)
            GRP_STEADY:
                for (int k = 0; k < GROUP_LEN; k++)
                    g.push_back(DATA_W'(base + $urandom_range(0, SPREAD_LIMIT)));
            GRP_BROKEN:
            begin
                lo = $urandom_range(0, 4000);
                d  = $urandom_range(31, 4095 - lo);
                for (int k = 0; k < GROUP_LEN; k++)
                    g.push_back(DATA_W'(lo + $urandom_range(0, d)));
                // force both ends of the spread into the group
                a = $urandom_range(0, GROUP_LEN - 1);
                g[a] = DATA_W'(lo);
                g[(a + 1 + $urandom_range(0, GROUP_LEN - 2)) % GROUP_LEN] = DATA_W'(lo + d);
            end
            default:
                for (int k = 0; k < GROUP_LEN; k++)
                    g.push_back(DATA_W'($urandom_range(0, 4095)));
        endcase
        return g;
    endfunction

    // frames of pressure, X and Y groups; mostly steady groups, some broken or noise
    function automatic sample_q_t make_frames(input int min_items);
        sample_q_t   q;
        sample_q_t   g;
        group_kind_t kind;
        int          roll;
        int          base;
        int          off;
        int          span;
        int          lo;
        int          hi;
        while (q.size() < min_items)
        begin
            for (int grp = 0; grp < 3; grp++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 8)
                    kind = GRP_BROKEN;
                else if (roll < 14)
                    kind = GRP_NOISE;
                else
                    kind = GRP_STEADY;

                if (grp == 0)
                begin
                    if (int'(cal_thr) < BASE_MAX && $urandom_range(0, 99) < 85)
                        base = $urandom_range(int'(cal_thr) + 1, BASE_MAX);
                    else
                        base = $urandom_range(0, (int'(cal_thr) < BASE_MAX) ?
                                              int'(cal_thr) : BASE_MAX);
                end
                else if ($urandom_range(0, 1) == 1)
                    base = $urandom_range(0, BASE_MAX);
                else
                begin
                    // near the calibrated window, a little below the offset too
                    off  = $urandom_range(0, 1) ? int'(cal_off_x) : int'(cal_off_y);
                    span = $urandom_range(0, 1) ? int'(cal_span_x) : int'(cal_span_y);
                    lo   = (off > 60) ? off - 60 : 0;
                    hi   = off + span;
                    if (hi > BASE_MAX)
                        hi = BASE_MAX;
                    if (lo > hi)
                        lo = hi;
                    base = $urandom_range(lo, hi);
                end
                g = make_group(kind, base);
                foreach (g[k])
                    q.push_back(g[k]);
            end
        end
        return q;
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    // one sample transfer; valid stays high unless this ends a burst
    task automatic send_sample(input logic [DATA_W-1:0] value, input bit last);
        sample_valid <= 1'b1;
        sample       <= value;
        do
            @(posedge clk);
        while (sample_stall);
        pending_results.push_back(predict_touch_result(value));
        @(negedge clk);
        if (last)
            sample_valid <= 1'b0;
    endtask

    task automatic drive_samples(input sample_q_t q, input bit back_to_back);
        int idx;
        int burst;
        idx = 0;
        while (idx < q.size())
        begin
            if (back_to_back)
                burst = q.size();
            else if ($urandom_range(0, 9) == 0)
                burst = $urandom_range(20, 60);
            else
                burst = $urandom_range(1, 6);
            for (int k = 0; k < burst && idx < q.size(); k++)
            begin
                send_sample(q[idx], (k == burst - 1) || (idx == q.size() - 1));
                idx++;
            end
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
    endtask

    // sender pauses until every expected result is back
    task automatic wait_results_drained();
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // write enable is left high for back-to-back writes; caller lowers it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        model_reg_write(idx, value);
    endtask

    task automatic load_touch_config(input touch_cfg_t c);
        write_reg(REG_OFFSET_X, c.off_x);
        write_reg(REG_SPAN_X, c.span_x);
        write_reg(REG_OFFSET_Y, c.off_y);
        write_reg(REG_SPAN_Y, c.span_y);
        write_reg(REG_ORIENT, c.orient);
        write_reg(REG_SCREEN_W, c.width);
        write_reg(REG_SCREEN_H, c.height);
        write_reg(REG_THRESHOLD, c.thr);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    function automatic touch_cfg_t realistic_config();
        touch_cfg_t c;
        c.off_x  = DATA_W'($urandom_range(100, 500));
        c.span_x = DATA_W'($urandom_range(3000, 3800));
        c.off_y  = DATA_W'($urandom_range(100, 500));
        c.span_y = DATA_W'($urandom_range(3000, 3800));
        c.orient = DATA_W'($urandom_range(0, 7));
        c.width  = DATA_W'($urandom_range(240, 800));
        c.height = DATA_W'($urandom_range(240, 480));
        c.thr    = DATA_W'($urandom_range(0, 200));
        return c;
    endfunction

    function automatic touch_cfg_t random_config();
        touch_cfg_t c;
        c.off_x  = DATA_W'($urandom_range(0, 4095));
        c.span_x = DATA_W'($urandom_range(0, 4095));
        c.off_y  = DATA_W'($urandom_range(0, 4095));
        c.span_y = DATA_W'($urandom_range(0, 4095));
        c.orient = DATA_W'($urandom_range(0, 4095));   // upper bits are ignored
        c.width  = DATA_W'($urandom_range(0, 4095));
        c.height = DATA_W'($urandom_range(0, 4095));
        c.thr    = DATA_W'($urandom_range(0, 1000));
        return c;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // all-zero pressure, then pressure average exactly at threshold
    task automatic test_no_touch_frames();
        sample_q_t q;
        q = '{12'd0, 12'd0, 12'd0, 12'd0, 12'd40, 12'd41, 12'd39, 12'd40};
        drive_samples(q, 1'b0);
        wait_results_drained();
    endtask

    // spread of 31 is rejected, spread of 30 at full scale is kept
    task automatic test_group_spread();
        sample_q_t q;
        q = '{12'd100, 12'd131, 12'd115, 12'd120, 12'd4095, 12'd4065, 12'd4080, 12'd4095};
        drive_samples(q, 1'b0);
        wait_results_drained();
    endtask

    // X at zero, Y at full scale: point lands off screen with reset calibration
    task automatic test_frame_extremes();
        sample_q_t q;
        q = '{12'd0, 12'd0, 12'd0, 12'd0, 12'd4095, 12'd4095, 12'd4095, 12'd4095};
        drive_samples(q, 1'b0);
        wait_results_drained();
    endtask

    task automatic test_calibration_extremes();
        touch_cfg_t c;
        // zero offsets and spans turn into one, widest screen, no threshold
        c = '{12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd4095, 12'd4095, 12'd0};
        load_touch_config(c);
        drive_samples(make_frames(50), 1'b0);
        wait_results_drained();
        // top offsets and spans, all orientation flags, 1x1 screen, threshold never passed
        c = '{12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'hFFF, 12'd1, 12'd1, 12'd4095};
        load_touch_config(c);
        drive_samples(make_frames(36), 1'b0);
        wait_results_drained();
        // zero screen size: nothing is ever on screen
        c = realistic_config();
        c.width  = '0;
        c.height = '0;
        load_touch_config(c);
        drive_samples(make_frames(50), 1'b0);
        wait_results_drained();
    endtask

    task automatic test_random_calibration();
        for (int ph = 0; ph < 7; ph++)
        begin
            load_touch_config(($urandom_range(0, 1) == 1) ? realistic_config() : random_config());
            drive_samples(make_frames(60), 1'b0);
            wait_results_drained();
        end
    endtask

    // receiver holds off long while samples keep coming, so input stalls
    task automatic test_backpressure();
        load_touch_config(realistic_config());
        holdoff_request = 1'b1;
        drive_samples(make_frames(40), 1'b1);
        wait_results_drained();
    endtask

    // ------------------------------------------------------------------
    // receiver stall pattern
    // ------------------------------------------------------------------
    initial
    begin : receiver
        int mode;
        int mode_left;
        mode         = 0;
        mode_left    = 0;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holdoff_request)
            begin
                holdoff_request = 1'b0;
                result_stall <= 1'b1;
                repeat (HOLDOFF_CYCLES - 1) @(negedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    0: result_stall <= 1'b0;
                    1: result_stall <= ($urandom_range(0, 7) == 0);
                    2: result_stall <= ($urandom_range(0, 1) == 1);
                    default: result_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        touch_result_t exp_r;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                if (mismatch_count < MAX_REPORTS)
                    $display("unexpected result transfer: axis=%0d done=%0d", next_axis,
                             frame_done);
                mismatch_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (next_axis !== exp_r.next_axis || frame_done !== exp_r.frame_done ||
                    touched !== exp_r.touched || on_screen !== exp_r.on_screen ||
                    pos_x !== exp_r.pos_x || pos_y !== exp_r.pos_y ||
                    pressure !== exp_r.pressure)
                begin
                    if (mismatch_count < MAX_REPORTS)
                    begin
                        $display("mismatch exp: axis=%0d done=%0d touch=%0d on=%0d x=%0d y=%0d p=%0d",
                                 exp_r.next_axis, exp_r.frame_done, exp_r.touched,
                                 exp_r.on_screen, exp_r.pos_x, exp_r.pos_y, exp_r.pressure);
                        $display("         got: axis=%0d done=%0d touch=%0d on=%0d x=%0d y=%0d p=%0d",
                                 next_axis, frame_done, touched, on_screen, pos_x, pos_y,
                                 pressure);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog: cycles without any transfer
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (sample_valid && !sample_stall) || (result_valid && !result_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin : sequencer
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = REG_OFFSET_X;
        cfg_data        = '0;
        sample_valid    = 1'b0;
        sample          = '0;
        holdoff_request = 1'b0;
        mismatch_count  = 0;
        reset_touch_model();
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_no_touch_frames();
        test_group_spread();
        test_frame_extremes();
        test_calibration_extremes();
        test_random_calibration();
        test_backpressure();

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
